### sv/lkvc_pkg.sv
// Package: shared types and constants for the LRU key/value cache.
package lkvc_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_SET = 1'b1
  } mode_t;

  // Request item as it travels from the front to the back
  typedef struct packed {
    mode_t            mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  // Result item
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } rsp_t;

endpackage

### sv/lkvc_front.sv
// Front end: accepts request items into a short queue feeding the back end.
module lkvc_front #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lkvc_pkg::req_t    in_req,
  output logic              q_valid,
  input  logic              q_ready,
  output lkvc_pkg::req_t    q_req
);
  import lkvc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  req_t            mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            push, pop;

  assign in_ready = (cnt_r != (PW+1)'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_req    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Pointer and count update
  always_comb begin
    wp_nxt  = push ? ((wp_r == PW'(DEPTH-1)) ? '0 : wp_r + PW'(1)) : wp_r;
    rp_nxt  = pop  ? ((rp_r == PW'(DEPTH-1)) ? '0 : rp_r + PW'(1)) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req;
  end

endmodule

### sv/lkvc_back.sv
// Back end: parallel tag match, LRU rank update and result register.
module lkvc_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lkvc_pkg::CAP_W-1:0]  capacity,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  lkvc_pkg::req_t              q_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lkvc_pkg::rsp_t              out_rsp
);
  import lkvc_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned UW = $clog2(DEPTH + 1);

  logic [KEY_W-1:0] keys_r [DEPTH];
  logic [VAL_W-1:0] vals_r [DEPTH];
  logic [IW-1:0]    rank_r [DEPTH];
  logic [IW-1:0]    rank_nxt [DEPTH];
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [UW-1:0]    used_r, used_nxt, eff_cap;
  logic             ovalid_r;
  rsp_t             rsp_r, rsp_nxt;

  logic             go, hit, has_free, lru_ok;
  logic [IW-1:0]    hit_idx, free_idx, lru_idx, tgt, trank;
  logic             do_touch, was_ranked, wr_key, wr_val;

  assign q_ready   = !ovalid_r || out_ready;
  assign go        = q_valid && q_ready;
  assign out_valid = ovalid_r;
  assign out_rsp   = rsp_r;

  // Effective capacity: zero means one, saturated at the store depth
  always_comb begin
    if (capacity == '0)
      eff_cap = UW'(1);
    else if (32'(capacity) > DEPTH)
      eff_cap = UW'(DEPTH);
    else
      eff_cap = UW'(capacity);
  end

  // Priority searches: lowest matching index wins
  always_comb begin
    hit = 1'b0; hit_idx = '0;
    has_free = 1'b0; free_idx = '0;
    lru_ok = 1'b0; lru_idx = '0;
    for (int i = DEPTH-1; i >= 0; i--) begin
      if (valid_r[i] && keys_r[i] == q_req.key) begin
        hit = 1'b1; hit_idx = IW'(i);
      end
      if (!valid_r[i]) begin
        has_free = 1'b1; free_idx = IW'(i);
      end
      // rank of least recent valid entry is used_count-1
      if (valid_r[i] && 32'(rank_r[i]) == 32'(used_r) - 1) begin
        lru_ok = 1'b1; lru_idx = IW'(i);
      end
    end
  end

  // Decide the action for this item
  always_comb begin
    rsp_nxt    = '0;
    tgt        = hit_idx;
    do_touch   = 1'b0;
    was_ranked = 1'b1;
    wr_key     = 1'b0;
    wr_val     = 1'b0;
    used_nxt   = used_r;
    valid_nxt  = valid_r;
    if (q_req.mode == MODE_GET) begin
      if (hit) begin
        rsp_nxt.found      = 1'b1;
        rsp_nxt.read_value = vals_r[hit_idx];
        do_touch           = 1'b1;
      end else begin
        rsp_nxt.read_value = MISS_VALUE;
      end
    end else if (hit) begin
      rsp_nxt.found = 1'b1;
      do_touch      = 1'b1;
      wr_val        = 1'b1;
    end else if (used_r < eff_cap) begin
      if (has_free) begin
        tgt        = free_idx;
        do_touch   = 1'b1;
        was_ranked = 1'b0;
        wr_key     = 1'b1;
        wr_val     = 1'b1;
        valid_nxt[free_idx] = 1'b1;
        used_nxt   = used_r + UW'(1);
      end
    end else if (lru_ok) begin
      tgt             = lru_idx;
      do_touch        = 1'b1;
      wr_key          = 1'b1;
      wr_val          = 1'b1;
      rsp_nxt.evicted = 1'b1;
    end
  end

  // Rank update: the target becomes most recent; entries more recent than it (all valid ones on a fill) age by one
  assign trank = rank_r[tgt];
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      rank_nxt[i] = rank_r[i];
      if (do_touch) begin
        if (IW'(i) == tgt)
          rank_nxt[i] = '0;
        else if (valid_r[i] && (!was_ranked || rank_r[i] < trank))
          rank_nxt[i] = rank_r[i] + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      used_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (go) begin
        valid_r <= valid_nxt;
        used_r  <= used_nxt;
      end
      if (go)
        ovalid_r <= 1'b1;
      else if (out_ready)
        ovalid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (go) begin
      rsp_r <= rsp_nxt;
      for (int i = 0; i < DEPTH; i++) rank_r[i] <= rank_nxt[i];
      if (wr_key) keys_r[tgt] <= q_req.key;
      if (wr_val) vals_r[tgt] <= q_req.value;
    end
  end

endmodule

### sv/lru_key_value_cache.sv
// Top level: LRU key/value cache with configuration register.
// Fully associative key/value cache of STORE_DEPTH entries with LRU
// replacement. Each request item yields one result item. Items pass through
// a two-entry input queue into the back end, which does the tag match and
// recency update and registers the result, so the sustained rate is one item per
// clock while out_ready stays high. The capacity register (reset 16) limits the
// entries in use; the user must write it while idle; the block does not enforce it.
module lru_key_value_cache #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_capacity,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic signed [31:0] out_read_value,
  output logic        out_evicted
);
  import lkvc_pkg::*;

  logic [CAP_W-1:0] cap_r;
  req_t in_req, q_req;
  rsp_t rsp;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n)
      cap_r <= CAP_RESET;
    else if (cfg_valid)
      cap_r <= cfg_capacity;
  end

  assign in_req.mode  = mode_t'(in_mode);
  assign in_req.key   = in_key;
  assign in_req.value = in_value;

  lkvc_front #(.DEPTH(2)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  lkvc_back #(.DEPTH(STORE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .capacity(cap_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(rsp)
  );

  assign out_found      = rsp.found;
  assign out_read_value = rsp.read_value;
  assign out_evicted    = rsp.evicted;

endmodule

### tb/tb_lru_key_value_cache.sv
// Testbench for the LRU key/value cache: directed and random gets/sets checked against a predictor.
`timescale 1ns / 100ps

module tb_lru_key_value_cache;
  import lkvc_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_capacity = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic signed [31:0] in_key = '0;
  logic signed [31:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic signed [31:0] out_read_value;
  logic out_evicted;

  lru_key_value_cache dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_capacity(cfg_capacity),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_read_value(out_read_value), .out_evicted(out_evicted)
  );

  always #4 clk = ~clk;

  // Predictor state
  logic [KEY_W-1:0] pk_keys [DEPTH];
  logic [VAL_W-1:0] pk_vals [DEPTH];
  logic pk_valid [DEPTH];
  int unsigned pk_rank [DEPTH];
  int unsigned pk_used;
  logic [4:0] pk_capacity;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  int n_hits = 0, n_evicts = 0, n_results = 0;
  int idle_cycles = 0;

  // Promote entry idx to most recent
  function automatic void promote(int idx, bit was_ranked);
    int unsigned r;
    r = pk_rank[idx];
    for (int i = 0; i < DEPTH; i++)
      if (i != idx && pk_valid[i] && (!was_ranked || pk_rank[i] < r))
        pk_rank[i]++;
    pk_rank[idx] = 0;
  endfunction

  function automatic rsp_t predict_lookup(req_t rq);
    rsp_t rs;
    int hit, slot, lru;
    int unsigned cap, best;
    rs = '0;
    hit = -1;
    for (int i = 0; i < DEPTH; i++)
      if (hit < 0 && pk_valid[i] && pk_keys[i] == rq.key) hit = i;
    cap = (pk_capacity == 0) ? 1 : (pk_capacity > DEPTH ? DEPTH : pk_capacity);
    if (rq.mode == MODE_GET) begin
      if (hit >= 0) begin
        rs.found = 1'b1;
        rs.read_value = pk_vals[hit];
        promote(hit, 1'b1);
      end else begin
        rs.read_value = MISS_VALUE;
      end
    end else if (hit >= 0) begin
      rs.found = 1'b1;
      pk_vals[hit] = rq.value;
      promote(hit, 1'b1);
    end else if (pk_used < cap) begin
      slot = -1;
      for (int i = 0; i < DEPTH; i++)
        if (slot < 0 && !pk_valid[i]) slot = i;
      promote(slot, 1'b0);
      pk_keys[slot] = rq.key;
      pk_vals[slot] = rq.value;
      pk_valid[slot] = 1'b1;
      pk_used++;
    end else begin
      lru = -1;
      best = 0;
      for (int i = 0; i < DEPTH; i++)
        if (pk_valid[i] && (lru < 0 || pk_rank[i] > best)) begin
          lru = i;
          best = pk_rank[i];
        end
      promote(lru, 1'b1);
      pk_keys[lru] = rq.key;
      pk_vals[lru] = rq.value;
      rs.evicted = 1'b1;
    end
    return rs;
  endfunction

  // Driver: bursts with random gaps; holds payload until accepted
  int burst_left = 0, gap_left = 0;
  bit hold_off = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(predict_lookup(req_t'{mode_t'(in_mode), in_key, in_value}));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || hold_off || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          req_t rq;
          rq = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_mode <= rq.mode;
          in_key <= rq.key;
          in_value <= rq.value;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver stall pattern and result check
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase % 64 < 20) ? 1'b1 : ($urandom_range(3, 0) != 0);
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          rsp_t ex;
          ex = expected_rsps.pop_front();
          n_results++;
          if (ex.found) n_hits++;
          if (ex.evicted) n_evicts++;
          if (out_found !== ex.found) begin
            $error("found: expected %0d, got %0d", ex.found, out_found);
            errors++;
          end
          if (out_read_value !== ex.read_value) begin
            $error("read_value: expected %0h, got %0h", ex.read_value, out_read_value);
            errors++;
          end
          if (out_evicted !== ex.evicted) begin
            $error("evicted: expected %0d, got %0d", ex.evicted, out_evicted);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any input, result or configuration handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_lru_key_value_cache: done, errors");
        $finish;
      end
    end
  end

  task automatic add_req(mode_t m, logic [31:0] k, logic [31:0] v);
    pending_reqs.push_back(req_t'{m, k, v});
  endtask

  // Wait until everything sent has been answered
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [4:0] cap);
    cfg_capacity <= cap;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    pk_capacity = cap;
    cfg_valid <= 1'b0;
  endtask

  // Random phase: keys from a small pool so hits and evictions are common
  task automatic random_phase(int count, int pool);
    logic [31:0] k;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9, 0) == 0) k = $urandom();
      else k = 32'h5A00_0000 ^ $urandom_range(pool - 1, 0);
      add_req(mode_t'($urandom_range(1, 0)), k, $urandom());
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      pk_valid[i] = 1'b0;
      pk_rank[i] = 0;
      pk_keys[i] = '0;
      pk_vals[i] = '0;
    end
    pk_used = 0;
    pk_capacity = CAP_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme keys and values, get miss/hit, set hit, evictions
    write_capacity(5'd2);
    add_req(MODE_GET, 32'h8000_0000, 32'h0);
    add_req(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    add_req(MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    add_req(MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    add_req(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(MODE_GET, 32'h7FFF_FFFF, 32'h0);
    add_req(MODE_SET, 32'h0, 32'h0);
    add_req(MODE_SET, 32'h0, 32'h1234_5678);
    add_req(MODE_GET, 32'h0, 32'h0);
    add_req(MODE_GET, 32'hFFFF_FFFF, 32'h0);
    drain();
    // Capacity zero acts as one; lowering below the fill drops nothing
    write_capacity(5'd0);
    add_req(MODE_SET, 32'h1, 32'h11);
    add_req(MODE_GET, 32'h0, 32'h0);
    add_req(MODE_SET, 32'h2, 32'h22);
    add_req(MODE_GET, 32'h1, 32'h0);
    drain();
    // Oversized capacity saturates to the depth
    write_capacity(5'd31);
    random_phase(200, 24);
    drain();
    write_capacity(5'd1);
    random_phase(120, 4);
    // Hold off partway through until all results are back
    while (pending_reqs.size() > 60) @(posedge clk);
    hold_off = 1'b1;
    while (in_valid || expected_rsps.size() != 0) @(posedge clk);
    hold_off = 1'b0;
    drain();
    write_capacity(5'd16);
    random_phase(260, 28);
    drain();
    write_capacity(5'd7);
    random_phase(250, 12);
    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d results: %0d hits, %0d evictions, capacities 0,1,2,7,16,31.",
             n_results, n_hits, n_evicts);
    if (errors == 0) begin
      $display("tb_lru_key_value_cache: done, clean");
    end else begin
      $display("tb_lru_key_value_cache: done, errors");
    end
    $finish;
  end

endmodule
